// ----- rtl/core/hall_sensor_angle_speed_estimator_top_assert.svh -----
// Assertion macros for the Hall sensor angle and speed estimator.
// Used by the RTL files in rtl/core; no other dependencies.
`ifndef HALL_SENSOR_ANGLE_SPEED_ESTIMATOR_TOP_ASSERT_SVH
`define HALL_SENSOR_ANGLE_SPEED_ESTIMATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HALLEST_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hallest assertion failed");

// Next-cycle implication, disabled during reset.
`define HALLEST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hallest assertion failed");

`endif

// ----- rtl/core/hallest_pkg.sv -----
// Package for the Hall sensor angle and speed estimator: widths, codes,
// word types, divider interface and the Hall sector table. No dependencies.
package hallest_pkg;

   localparam int ANGLE_FRAC_BITS = 24;
   localparam int TIMER_BITS      = 32;
   localparam int MS_COUNTER_BITS = 16;

   localparam int NOM_BITS     = 32;
   localparam int TIMEOUT_BITS = 16;
   localparam int SPEED_BITS   = 32;
   localparam int MAG_BITS     = SPEED_BITS - 1;
   localparam int MS_CMP_BITS  = (MS_COUNTER_BITS > TIMEOUT_BITS) ? MS_COUNTER_BITS
                                                                  : TIMEOUT_BITS;

   // divider geometry: dividend padded to an even width, two bits per step
   localparam int DIVIDEND_BITS = NOM_BITS + ANGLE_FRAC_BITS;
   localparam int DIV_W         = DIVIDEND_BITS + (DIVIDEND_BITS % 2);
   localparam int DVSR_W        = TIMER_BITS;
   localparam int DIV_STEPS     = DIV_W / 2;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

   localparam longint unsigned ONE_TURN = 64'd1 << ANGLE_FRAC_BITS;
   localparam logic [ANGLE_FRAC_BITS-1:0] ANG_SIXTH   = ANGLE_FRAC_BITS'(ONE_TURN / 6);
   localparam logic [ANGLE_FRAC_BITS-1:0] ANG_TWELFTH = ANGLE_FRAC_BITS'(ONE_TURN / 12);
   localparam logic [ANGLE_FRAC_BITS-1:0] ANG_THIRD   = ANGLE_FRAC_BITS'(ONE_TURN / 3);
   localparam logic [ANGLE_FRAC_BITS-1:0] ANG_HALF    = ANGLE_FRAC_BITS'(ONE_TURN / 2);
   localparam logic [ANGLE_FRAC_BITS-1:0] ANG_2THIRD  = ANGLE_FRAC_BITS'((2 * ONE_TURN) / 3);
   localparam logic [ANGLE_FRAC_BITS-1:0] ANG_5SIXTH  = ANGLE_FRAC_BITS'((5 * ONE_TURN) / 6);
   localparam logic [MAG_BITS-1:0]        MAG_MAX     = '1;

   // operation codes
   localparam logic [1:0] OP_HALL   = 2'd0;
   localparam logic [1:0] OP_EDGE   = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_UPDATE = 2'd3;

   // configuration register indexes
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NOMINAL_PERIOD = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIMEOUT_MS     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPEED_MIN      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANGLE_OFFSET   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_USER_DIRECTION = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INTERP_ENABLE  = 3'd5;

   typedef struct packed {
      logic [1:0]            op;
      logic [2:0]            hall_bits;
      logic [1:0]            channel;
      logic [TIMER_BITS-1:0] timestamp;
   } hallest_req_type;

   typedef struct packed {
      logic [ANGLE_FRAC_BITS-1:0] angle;
      logic signed [SPEED_BITS-1:0] speed;
      logic                       direction;
      logic                       stopped;
      logic                       running;
      logic [2:0]                 hall_code;
   } hallest_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVSR_W-1:0] divisor;
   } hallest_div_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } hallest_div_res_type;

   // Hall code to sector start angle; MSB flags a legal code
   function automatic logic [ANGLE_FRAC_BITS:0] hallest_sector(input logic [2:0] code);
      logic [ANGLE_FRAC_BITS:0] res;
      case (code)
         3'd5:    res = {1'b1, {ANGLE_FRAC_BITS{1'b0}}};
         3'd4:    res = {1'b1, ANG_SIXTH};
         3'd6:    res = {1'b1, ANG_THIRD};
         3'd2:    res = {1'b1, ANG_HALF};
         3'd3:    res = {1'b1, ANG_2THIRD};
         3'd1:    res = {1'b1, ANG_5SIXTH};
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

// ----- rtl/core/hall_sensor_angle_speed_estimator_top.sv -----
// Top level of the Hall sensor angle and speed estimator: state, sequencer,
// config registers, output register. Depends on hallest_pkg and hallest_div.
//
// Usage:
//  req_*  : input words (op, hall_bits, channel, timestamp). A word is taken
//           when req_valid is high and req_stall low.
//  rsp_*  : one result word per input word, held in an output register until
//           taken (rsp_valid high, rsp_stall low).
//  csr_*  : register writes, index plus data; csr_ready is always high.
//           Write only while the block is idle.
//  Sequencing: a Hall sample, capture edge or ms tick goes from idle to the
//  done state, which loads the output register. An update runs up to two
//  56-by-32 divisions on the one shared divider, each a load plus 28 two-bit
//  steps, through the angle start, wait and sum states, then speed start,
//  speed wait, flags and done, skipping a wait whose division is not needed.
//  One word in work at a time; the sequencer is back in idle as the result
//  is loaded. A stalled receiver holds the sequencer in its final state.
//  Reset (synchronous, active high) clears the estimator state, sequencer and
//  rsp_valid and loads the register defaults; no clearing pass is needed.
`include "hall_sensor_angle_speed_estimator_top_assert.svh"

module hall_sensor_angle_speed_estimator_top import hallest_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hallest_req_type         req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hallest_rsp_type         rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [NOM_BITS-1:0]     csr_wdata
);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_ANG_START = 8'b0000_0010,
      S_ANG_WAIT  = 8'b0000_0100,
      S_ANG_SUM   = 8'b0000_1000,
      S_SPD_START = 8'b0001_0000,
      S_SPD_WAIT  = 8'b0010_0000,
      S_FLAGS     = 8'b0100_0000,
      S_DONE      = 8'b1000_0000
   } hallest_state_type;

   hallest_state_type state_ff, state_in;

   // configuration
   logic [NOM_BITS-1:0]        nominal_ff, nominal_in;
   logic [TIMEOUT_BITS-1:0]    timeout_ff, timeout_in;
   logic [MAG_BITS-1:0]        speed_min_ff, speed_min_in;
   logic [ANGLE_FRAC_BITS-1:0] offset_ff, offset_in;
   logic                       user_dir_ff, user_dir_in;
   logic                       interp_ff, interp_in;

   // estimator state
   logic [1:0]                 edge_count_ff, edge_count_in;
   logic [1:0]                 last_ch_ff, last_ch_in;
   logic                       dir_now_ff, dir_now_in;
   logic                       dir_prev_ff, dir_prev_in;
   logic [TIMER_BITS-1:0]      last_edge_ff, last_edge_in;
   logic [TIMER_BITS-1:0]      ch_time_ff [3];
   logic [TIMER_BITS-1:0]      ch_time_in [3];
   logic [TIMER_BITS-1:0]      sector_per_ff, sector_per_in;
   logic [TIMER_BITS-1:0]      cycle_per_ff, cycle_per_in;
   logic [MS_COUNTER_BITS-1:0] ms_ff, ms_in;
   logic                       zero_ff, zero_in;
   logic [ANGLE_FRAC_BITS-1:0] sector_ang_ff, sector_ang_in;
   logic [SPEED_BITS-1:0]      speed_ff, speed_in;
   logic                       running_ff, running_in;
   logic [ANGLE_FRAC_BITS-1:0] angle_ff, angle_in;
   logic [2:0]                 code_ff, code_in;

   // update scratch
   logic [TIMER_BITS-1:0]      upd_time_ff, upd_time_in;
   logic [ANGLE_FRAC_BITS-1:0] interp_a_ff, interp_a_in;
   logic [MAG_BITS-1:0]        mag_ff, mag_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   hallest_rsp_type            rsp_data_ff, rsp_data_in;

   hallest_div_cmd_type div_cmd;
   hallest_div_res_type div_res;

   hallest_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_res (div_res)
   );

   logic                       req_take;
   logic                       upd_take;
   logic                       rsp_free;
   logic                       timed_out;
   logic [2:0]                 code_w;
   logic [ANGLE_FRAC_BITS:0]   sector_w;
   logic [1:0]                 pred_ch, succ_ch;
   logic [TIMER_BITS-1:0]      since_edge, ch_prev_time;
   logic [TIMER_BITS+1:0]      six_full;
   logic [TIMER_BITS-1:0]      upd_delta;
   logic [ANGLE_FRAC_BITS-1:0] a_final;
   logic [MAG_BITS-1:0]        mag_sat;
   logic                       flip;

   assign req_take  = req_valid && !req_stall;
   assign upd_take  = req_take && (req_data.op == OP_UPDATE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign timed_out = (MS_CMP_BITS'(ms_ff) > MS_CMP_BITS'(timeout_ff));
   // direction bit and user reversal cancel each other
   assign flip      = dir_now_ff ^ user_dir_ff;

   // Hall code, optionally with pins A and C swapped
   assign code_w   = user_dir_ff ? {req_data.hall_bits[0], req_data.hall_bits[1],
                                    req_data.hall_bits[2]} : req_data.hall_bits;
   assign sector_w = hallest_sector(code_w);

   // neighbor channels in the 1-2-3 rotation
   assign pred_ch = (req_data.channel == 2'd1) ? 2'd3 : req_data.channel - 2'd1;
   assign succ_ch = (req_data.channel == 2'd3) ? 2'd1 : req_data.channel + 2'd1;

   always_comb begin
      case (req_data.channel)
         2'd1:    ch_prev_time = ch_time_ff[0];
         2'd2:    ch_prev_time = ch_time_ff[1];
         2'd3:    ch_prev_time = ch_time_ff[2];
         default: ch_prev_time = '0;
      endcase
   end

   assign since_edge = req_data.timestamp - last_edge_ff;
   // six times the inter-edge time, wraps at timer width
   assign six_full   = {since_edge, 2'b00} + {1'b0, since_edge, 1'b0};
   assign upd_delta  = upd_time_ff - last_edge_ff;
   assign a_final    = flip ? (ANG_SIXTH - interp_a_ff) : interp_a_ff;
   assign mag_sat    = (div_res.quotient > DIV_W'(MAG_MAX)) ? MAG_MAX
                                                            : div_res.quotient[MAG_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      nominal_in    = nominal_ff;
      timeout_in    = timeout_ff;
      speed_min_in  = speed_min_ff;
      offset_in     = offset_ff;
      user_dir_in   = user_dir_ff;
      interp_in     = interp_ff;
      edge_count_in = edge_count_ff;
      last_ch_in    = last_ch_ff;
      dir_now_in    = dir_now_ff;
      dir_prev_in   = dir_prev_ff;
      last_edge_in  = last_edge_ff;
      ch_time_in    = ch_time_ff;
      sector_per_in = sector_per_ff;
      cycle_per_in  = cycle_per_ff;
      ms_in         = ms_ff;
      zero_in       = zero_ff;
      sector_ang_in = sector_ang_ff;
      speed_in      = speed_ff;
      running_in    = running_ff;
      angle_in      = angle_ff;
      code_in       = code_ff;
      upd_time_in   = upd_time_ff;
      interp_a_in   = interp_a_ff;
      mag_in        = mag_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      div_cmd       = '0;

      // config writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NOMINAL_PERIOD: nominal_in   = csr_wdata;
            CSR_TIMEOUT_MS:     timeout_in   = csr_wdata[TIMEOUT_BITS-1:0];
            CSR_SPEED_MIN:      speed_min_in = csr_wdata[MAG_BITS-1:0];
            CSR_ANGLE_OFFSET:   offset_in    = csr_wdata[ANGLE_FRAC_BITS-1:0];
            CSR_USER_DIRECTION: user_dir_in  = csr_wdata[0];
            CSR_INTERP_ENABLE:  interp_in    = csr_wdata[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DONE;
               case (req_data.op)
                  OP_HALL: begin
                     code_in = code_w;
                     // illegal codes keep the sector
                     if (sector_w[ANGLE_FRAC_BITS]) begin
                        sector_ang_in = sector_w[ANGLE_FRAC_BITS-1:0];
                     end
                  end
                  OP_EDGE: begin
                     if (req_data.channel != 2'd0) begin
                        if (edge_count_ff >= 2'd2) begin
                           zero_in = timed_out;
                           if (timed_out) begin
                              speed_in = '0;
                           end
                           if (last_ch_ff == pred_ch) begin
                              dir_now_in = 1'b0;
                           end else if (last_ch_ff == succ_ch) begin
                              dir_now_in = 1'b1;
                           end else if (last_ch_ff == req_data.channel) begin
                              dir_now_in = !dir_prev_ff;
                           end
                           dir_prev_in   = dir_now_in;
                           sector_per_in = six_full[TIMER_BITS-1:0];
                           last_edge_in  = req_data.timestamp;
                           cycle_per_in  = req_data.timestamp - ch_prev_time;
                           for (int i = 0; i < 3; i++) begin
                              if (req_data.channel == 2'(i + 1)) begin
                                 ch_time_in[i] = req_data.timestamp;
                              end
                           end
                           edge_count_in = 2'd3;
                        end else begin
                           sector_per_in = '0;
                           cycle_per_in  = '0;
                           edge_count_in = edge_count_ff + 2'd1;
                        end
                        ms_in      = '0;
                        last_ch_in = req_data.channel;
                     end
                  end
                  OP_TICK: begin
                     if (ms_ff != '1) begin
                        ms_in = ms_ff + 1'b1;
                     end
                  end
                  OP_UPDATE: begin
                     upd_time_in = req_data.timestamp;
                     state_in    = S_ANG_START;
                  end
                  default: ;
               endcase
            end
         end
         S_ANG_START: begin
            // angle uses the speed from before this update
            if (speed_ff == '0 || !interp_ff || sector_per_ff == '0) begin
               interp_a_in = ANG_TWELFTH;
               state_in    = S_ANG_SUM;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = DIV_W'({upd_delta, {ANGLE_FRAC_BITS{1'b0}}});
               div_cmd.divisor  = sector_per_ff;
               state_in         = S_ANG_WAIT;
            end
         end
         S_ANG_WAIT: begin
            if (div_res.done) begin
               // clamp to one sector
               interp_a_in = (div_res.quotient >= DIV_W'(ANG_SIXTH)) ? ANG_SIXTH
                             : div_res.quotient[ANGLE_FRAC_BITS-1:0];
               state_in    = S_ANG_SUM;
            end
         end
         S_ANG_SUM: begin
            angle_in = sector_ang_ff + a_final + offset_ff;
            state_in = S_SPD_START;
         end
         S_SPD_START: begin
            if (cycle_per_ff != '0 && !zero_ff) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = DIV_W'({nominal_ff, {ANGLE_FRAC_BITS{1'b0}}});
               div_cmd.divisor  = cycle_per_ff;
               state_in         = S_SPD_WAIT;
            end else begin
               speed_in = '0;
               mag_in   = '0;
               state_in = S_FLAGS;
            end
         end
         S_SPD_WAIT: begin
            if (div_res.done) begin
               mag_in   = mag_sat;
               speed_in = flip ? (SPEED_BITS'(0) - {1'b0, mag_sat}) : {1'b0, mag_sat};
               state_in = S_FLAGS;
            end
         end
         S_FLAGS: begin
            if (timed_out) begin
               speed_in   = '0;
               zero_in    = 1'b1;
               running_in = 1'b0;
            end else begin
               running_in = (mag_ff > speed_min_ff);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.angle     = angle_ff;
               rsp_data_in.speed     = speed_ff;
               rsp_data_in.direction = dir_now_ff;
               rsp_data_in.stopped   = zero_ff;
               rsp_data_in.running   = running_ff;
               rsp_data_in.hall_code = code_ff;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         nominal_ff    <= NOM_BITS'(1000000);
         timeout_ff    <= TIMEOUT_BITS'(1000);
         speed_min_ff  <= '0;
         offset_ff     <= '0;
         user_dir_ff   <= 1'b0;
         interp_ff     <= 1'b1;
         edge_count_ff <= '0;
         last_ch_ff    <= '0;
         dir_now_ff    <= 1'b0;
         dir_prev_ff   <= 1'b0;
         last_edge_ff  <= '0;
         for (int i = 0; i < 3; i++) begin
            ch_time_ff[i] <= '0;
         end
         sector_per_ff <= '0;
         cycle_per_ff  <= '0;
         ms_ff         <= '0;
         zero_ff       <= 1'b0;
         sector_ang_ff <= '0;
         speed_ff      <= '0;
         running_ff    <= 1'b0;
         angle_ff      <= '0;
         code_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nominal_ff    <= nominal_in;
         timeout_ff    <= timeout_in;
         speed_min_ff  <= speed_min_in;
         offset_ff     <= offset_in;
         user_dir_ff   <= user_dir_in;
         interp_ff     <= interp_in;
         edge_count_ff <= edge_count_in;
         last_ch_ff    <= last_ch_in;
         dir_now_ff    <= dir_now_in;
         dir_prev_ff   <= dir_prev_in;
         last_edge_ff  <= last_edge_in;
         ch_time_ff    <= ch_time_in;
         sector_per_ff <= sector_per_in;
         cycle_per_ff  <= cycle_per_in;
         ms_ff         <= ms_in;
         zero_ff       <= zero_in;
         sector_ang_ff <= sector_ang_in;
         speed_ff      <= speed_in;
         running_ff    <= running_in;
         angle_ff      <= angle_in;
         code_ff       <= code_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      upd_time_ff <= upd_time_in;
      interp_a_ff <= interp_a_in;
      mag_ff      <= mag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HALLEST_ASSERT_NEXT(a_update_starts_seq, clock, reset, upd_take, state_ff == S_ANG_START)
   `HALLEST_ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE))
   `HALLEST_ASSERT_IMPL(a_stopped_speed_zero, clock, reset, zero_ff, speed_ff == '0)

endmodule

// ----- rtl/core/hallest_div.sv -----
// Shared radix-2 restoring divider, two quotient bits per cycle.
// Depends on hallest_pkg; asserts through the top-level assertion header.
`include "hall_sensor_angle_speed_estimator_top_assert.svh"

module hallest_div import hallest_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  hallest_div_cmd_type div_cmd,
   output hallest_div_res_type div_res
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVSR_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DVSR_W-1:0]    dvsr_ff, dvsr_in;

   logic [DVSR_W-1:0] rem_w;
   logic [DIV_W-1:0]  quo_w;
   logic [DVSR_W:0]   trial;
   logic [DVSR_W:0]   diff;
   logic              ge;

   // two dependent compare/subtract steps
   always_comb begin
      rem_w = rem_ff;
      quo_w = quo_ff;
      trial = '0;
      diff  = '0;
      ge    = 1'b0;
      for (int k = 0; k < 2; k++) begin
         trial = {rem_w, quo_w[DIV_W-1]};
         diff  = trial - {1'b0, dvsr_ff};
         ge    = (trial >= {1'b0, dvsr_ff});
         rem_w = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
         quo_w = {quo_w[DIV_W-2:0], ge};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      if (div_cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         rem_in  = '0;
         quo_in  = div_cmd.dividend;
         dvsr_in = div_cmd.divisor;
      end else if (busy_ff) begin
         rem_in = rem_w;
         quo_in = quo_w;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_res.busy     = busy_ff;
   assign div_res.done     = done_ff;
   assign div_res.quotient = quo_ff;

   `HALLEST_ASSERT_IMPL(a_start_when_free, clock, reset, div_cmd.start, !busy_ff)
   `HALLEST_ASSERT_NEXT(a_done_one_cycle, clock, reset, done_ff, !done_ff)
   `HALLEST_ASSERT_IMPL(a_busy_has_count, clock, reset, busy_ff, cnt_ff != '0)

endmodule

// ----- tb/tb_hall_sensor_angle_speed_estimator_top.sv -----
// Self-checking testbench for hall_sensor_angle_speed_estimator_top: directed
// words, then rotor-like random traffic under four register settings.
// Depends on hallest_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_hall_sensor_angle_speed_estimator_top;
   import hallest_pkg::*;

   // Q24 turn fractions used by the predictor
   localparam longint unsigned TURN    = 64'd1 << ANGLE_FRAC_BITS;
   localparam longint unsigned SIXTH   = TURN / 6;
   localparam longint unsigned TWELFTH = TURN / 12;

   // Hall code of each 60-degree sector, sector 0 in the low bits; the
   // sector start angle is sector * TURN / 6
   localparam logic [5:0][2:0] SECTOR_CODE = {3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

   // ---------------------------------------------------------------------
   // Rotor estimate: register copies, estimator state and the words that
   // the block is expected to return, oldest first.
   // ---------------------------------------------------------------------
   class rotor_estimate;
      // registers
      logic [NOM_BITS-1:0]        nominal_period;
      logic [TIMEOUT_BITS-1:0]    timeout_ms;
      logic [MAG_BITS-1:0]        speed_min;
      logic [ANGLE_FRAC_BITS-1:0] angle_offset;
      logic                       user_direction;
      logic                       interp_enable;
      // estimator state
      logic [1:0]                 edge_count;
      logic [1:0]                 last_channel;
      logic                       dir_now;
      logic                       dir_prev;
      logic [TIMER_BITS-1:0]      last_edge_time;
      logic [TIMER_BITS-1:0]      channel_edge_time [3];
      logic [TIMER_BITS-1:0]      sector_period;
      logic [TIMER_BITS-1:0]      cycle_period;
      logic [MS_COUNTER_BITS-1:0] ms_since_edge;
      logic                       zero_flag;
      logic [ANGLE_FRAC_BITS-1:0] sector_angle;
      logic [SPEED_BITS-1:0]      speed_reg;
      logic                       running_flag;
      logic [ANGLE_FRAC_BITS-1:0] angle_reg;
      logic [2:0]                 code_reg;

      hallest_rsp_type expected_words[$];
      int mismatches;

      function new();
         nominal_period = 32'd1000000;
         timeout_ms     = 16'd1000;
         speed_min      = '0;
         angle_offset   = '0;
         user_direction = 1'b0;
         interp_enable  = 1'b1;
         edge_count     = '0;
         last_channel   = '0;
         dir_now        = 1'b0;
         dir_prev       = 1'b0;
         last_edge_time = '0;
         foreach (channel_edge_time[i]) channel_edge_time[i] = '0;
         sector_period  = '0;
         cycle_period   = '0;
         ms_since_edge  = '0;
         zero_flag      = 1'b0;
         sector_angle   = '0;
         speed_reg      = '0;
         running_flag   = 1'b0;
         angle_reg      = '0;
         code_reg       = '0;
         mismatches     = 0;
      endfunction

      function void write_register(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_NOMINAL_PERIOD: nominal_period = data;
            CSR_TIMEOUT_MS:     timeout_ms     = data[TIMEOUT_BITS-1:0];
            CSR_SPEED_MIN:      speed_min      = data[MAG_BITS-1:0];
            CSR_ANGLE_OFFSET:   angle_offset   = data[ANGLE_FRAC_BITS-1:0];
            CSR_USER_DIRECTION: user_direction = data[0];
            CSR_INTERP_ENABLE:  interp_enable  = data[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // invalid codes 0 and 7 keep the last sector angle
      function void hall_sample(logic [2:0] pins);
         logic [2:0] code;
         code = user_direction ? {pins[0], pins[1], pins[2]} : pins;
         code_reg = code;
         for (int i = 0; i < 6; i++)
            if (SECTOR_CODE[i] == code) sector_angle = ANGLE_FRAC_BITS'((i * TURN) / 6);
      endfunction

      function void capture(logic [1:0] ch, logic [TIMER_BITS-1:0] stamp);
         logic [1:0]            pred;
         logic [1:0]            succ;
         logic [TIMER_BITS-1:0] since;
         if (ch == 2'd0) return;
         if (edge_count >= 2'd2) begin
            edge_count = 2'd2;
            zero_flag = (ms_since_edge > timeout_ms);
            if (zero_flag) speed_reg = '0;
            pred = (ch == 2'd1) ? 2'd3 : ch - 2'd1;
            succ = (ch == 2'd3) ? 2'd1 : ch + 2'd1;
            if (last_channel == pred)      dir_now = 1'b0;
            else if (last_channel == succ) dir_now = 1'b1;
            else if (last_channel == ch)   dir_now = ~dir_prev;
            dir_prev = dir_now;
            since = stamp - last_edge_time;
            sector_period = since * 32'd6;
            last_edge_time = stamp;
            cycle_period = stamp - channel_edge_time[ch - 2'd1];
            channel_edge_time[ch - 2'd1] = stamp;
         end else begin
            // edges that come before the measurement is armed only arm it
            sector_period = '0;
            cycle_period  = '0;
         end
         edge_count    = edge_count + 2'd1;
         ms_since_edge = '0;
         last_channel  = ch;
      endfunction

      function void refresh(logic [TIMER_BITS-1:0] stamp);
         logic [TIMER_BITS-1:0] since;
         logic [63:0]           frac;
         logic [63:0]           quot;
         logic [SPEED_BITS-1:0] spd;
         logic [SPEED_BITS-1:0] mag;
         // angle uses the speed from before this update
         if (speed_reg == '0 || !interp_enable || sector_period == '0) begin
            frac = TWELFTH;
         end else begin
            since = stamp - last_edge_time;
            frac  = {32'd0, since} << ANGLE_FRAC_BITS;
            frac  = frac / sector_period;
            if (frac >= SIXTH) frac = SIXTH;
         end
         if (dir_now)        frac = SIXTH - frac;
         if (user_direction) frac = SIXTH - frac;
         angle_reg = sector_angle + frac[ANGLE_FRAC_BITS-1:0] + angle_offset;

         if (cycle_period != '0 && !zero_flag) begin
            quot = {32'd0, nominal_period} << ANGLE_FRAC_BITS;
            quot = quot / cycle_period;
            if (quot > 64'h7FFF_FFFF) quot = 64'h7FFF_FFFF;
            spd = quot[SPEED_BITS-1:0];
            if (dir_now)        spd = -spd;
            if (user_direction) spd = -spd;
         end else begin
            spd = '0;
         end
         speed_reg = spd;
         if (ms_since_edge > timeout_ms) begin
            speed_reg = '0;
            zero_flag = 1'b1;
         end
         mag = speed_reg[SPEED_BITS-1] ? -speed_reg : speed_reg;
         running_flag = (mag > {1'b0, speed_min});
      endfunction

      function void take_input_word(hallest_req_type w);
         hallest_rsp_type r;
         case (w.op)
            OP_HALL:   hall_sample(w.hall_bits);
            OP_EDGE:   capture(w.channel, w.timestamp);
            OP_TICK:   if (ms_since_edge != '1) ms_since_edge = ms_since_edge + 1'b1;
            OP_UPDATE: refresh(w.timestamp);
            default: ;
         endcase
         r.angle     = angle_reg;
         r.speed     = speed_reg;
         r.direction = dir_now;
         r.stopped   = zero_flag;
         r.running   = running_flag;
         r.hall_code = code_reg;
         expected_words.push_back(r);
      endfunction

      task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
         $display("%0t mismatch %0s: got %h, want %h", $realtime, field, got, want);
         mismatches++;
      endtask

      task compare_result_word(hallest_rsp_type got);
         hallest_rsp_type want;
         if (expected_words.size() == 0) begin
            report_mismatch("word with none expected", got.angle, 32'd0);
            return;
         end
         want = expected_words.pop_front();
         if (got.angle !== want.angle)         report_mismatch("angle", got.angle, want.angle);
         if (got.speed !== want.speed)         report_mismatch("speed", got.speed, want.speed);
         if (got.direction !== want.direction)
            report_mismatch("direction", got.direction, want.direction);
         if (got.stopped !== want.stopped)     report_mismatch("stopped", got.stopped, want.stopped);
         if (got.running !== want.running)     report_mismatch("running", got.running, want.running);
         if (got.hall_code !== want.hall_code)
            report_mismatch("hall_code", got.hall_code, want.hall_code);
      endtask
   endclass

   // ---------------------------------------------------------------------
   // Block hookup. Every input starts at a known value.
   // ---------------------------------------------------------------------
   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   hallest_req_type         req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   hallest_rsp_type         rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [NOM_BITS-1:0]     csr_wdata = '0;

   hall_sensor_angle_speed_estimator_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rotor_estimate rotor;

   // percent of cycles in which the sender idles / the receiver stalls
   int req_idle_pct  = 33;
   int rsp_stall_pct = 81;
   int words_sent;

   // virtual motor that feeds the well-formed part of the random traffic
   logic [31:0] motor_time;
   int          motor_sector;
   logic        motor_rev;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: check each word taken at this edge, then pick the stall
   // for the next edge. Both use the values from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         rotor.compare_result_word(rsp_data);
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Sends one word. Valid is left high after acceptance so that a word that
   // follows at once never sees valid lowered and raised in the same step.
   task automatic push_word(input logic [1:0] op, input logic [2:0] pins,
                            input logic [1:0] ch, input logic [31:0] stamp);
      hallest_req_type w;
      w.op        = op;
      w.hall_bits = pins;
      w.channel   = ch;
      w.timestamp = stamp;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rotor.take_input_word(w);
      // an edge on channel 0 is dropped by the block, so it does not count
      if (!(op == OP_EDGE && ch == 2'd0)) words_sent++;
   endtask

   // Drop valid and wait until every expected word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (rotor.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      rotor.write_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Register writes happen only with the block idle.
   task automatic configure(input logic [31:0] nom, input logic [31:0] tmo,
                            input logic [31:0] smin, input logic [31:0] offs,
                            input logic [31:0] udir, input logic [31:0] interp);
      drain();
      write_reg(CSR_NOMINAL_PERIOD, nom);
      write_reg(CSR_TIMEOUT_MS, tmo);
      write_reg(CSR_SPEED_MIN, smin);
      write_reg(CSR_ANGLE_OFFSET, offs);
      write_reg(CSR_USER_DIRECTION, udir);
      write_reg(CSR_INTERP_ENABLE, interp);
   endtask

   // One step of the virtual motor: Hall sample for the new sector, the
   // capture edge of the channel that switched, a few ms ticks, then one or
   // two updates somewhere inside (or just past) the sector. One group in
   // six is a single word with every field random.
   task automatic rotor_group();
      logic [31:0] dt;
      logic [31:0] span;
      logic [2:0]  code;
      logic [1:0]  ch;
      int          n;
      if ($urandom_range(5) == 0) begin
         push_word(2'($urandom), 3'($urandom), 2'($urandom), $urandom);
         return;
      end
      case ($urandom_range(19))
         0:       dt = 32'd0;                  // zero sector period
         1, 2:    dt = $urandom;               // very slow, timer may wrap
         default: dt = $urandom_range(40000, 200);
      endcase
      if ($urandom_range(11) == 0) motor_rev = ~motor_rev;
      // otherwise the same channel fires again (sensor chatter)
      if ($urandom_range(14) != 0)
         motor_sector = motor_rev ? (motor_sector + 5) % 6 : (motor_sector + 1) % 6;
      ch = 2'(motor_sector % 3 + 1);
      motor_time = motor_time + dt;
      code = SECTOR_CODE[motor_sector];
      if (rotor.user_direction) code = {code[0], code[1], code[2]};

      push_word(OP_HALL, code, 2'($urandom), $urandom);
      push_word(OP_EDGE, 3'($urandom), ch, motor_time);
      n = ($urandom_range(19) == 0) ? $urandom_range(20, 4) : $urandom_range(2, 0);
      repeat (n) push_word(OP_TICK, 3'($urandom), 2'($urandom), $urandom);
      span = (dt >= 32'hC000_0000) ? dt : dt + (dt >> 2);
      repeat ($urandom_range(2, 1))
         push_word(OP_UPDATE, 3'($urandom), 2'($urandom), motor_time + $urandom_range(span, 0));
   endtask

   task automatic run_rotor(input int target);
      words_sent   = 0;
      motor_time   = $urandom;
      motor_sector = $urandom_range(5);
      motor_rev    = 1'($urandom);
      while (words_sent < target) rotor_group();
   endtask

   initial begin
      rotor = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed words, register defaults ----
      push_word(OP_UPDATE, 3'd7, 2'd3, 32'hFFFF_FFFF);     // update straight after reset
      for (int p = 0; p < 8; p++)                          // all codes, 0 and 7 illegal
         push_word(OP_HALL, 3'(p), 2'(p), 32'(p));
      push_word(OP_EDGE, 3'd0, 2'd0, 32'hFFFF_FFFF);       // channel 0 is dropped
      push_word(OP_EDGE, 3'd0, 2'd1, 32'd1000);            // opening edges only arm
      push_word(OP_EDGE, 3'd0, 2'd2, 32'd2000);
      push_word(OP_EDGE, 3'd0, 2'd3, 32'd4096);            // forward order
      push_word(OP_UPDATE, 3'd0, 2'd0, 32'd4196);          // old speed zero: fixed angle
      push_word(OP_UPDATE, 3'd0, 2'd0, 32'd4596);          // now interpolated
      push_word(OP_EDGE, 3'd0, 2'd3, 32'd6000);            // same channel toggles direction
      push_word(OP_UPDATE, 3'd0, 2'd0, 32'd7000);
      push_word(OP_UPDATE, 3'd0, 2'd0, 32'd20000);         // past the sector: clamped
      push_word(OP_EDGE, 3'd0, 2'd2, 32'hFFFF_FF00);       // reverse order
      push_word(OP_EDGE, 3'd0, 2'd1, 32'h0000_0100);       // timer wrapped
      push_word(OP_UPDATE, 3'd0, 2'd0, 32'h0000_0180);
      push_word(OP_TICK, 3'd7, 2'd3, 32'd0);
      push_word(OP_HALL, 3'd4, 2'd0, 32'd0);
      push_word(OP_UPDATE, 3'd0, 2'd0, 32'd0);

      // ---- random traffic, sender idles a third, receiver stalls mostly ----
      // junk in the upper bits of narrow registers must be dropped
      configure($urandom_range(5000000, 1000), {16'($urandom), 16'($urandom_range(8, 0))},
                $urandom_range(32'h4000_0000, 0), $urandom,
                {31'($urandom), 1'b0}, {31'($urandom), 1'b1});
      run_rotor(175);
      // top of the period, speed and offset ranges: speed saturates, no interpolation, stop on first tick
      configure(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'h00FF_FFFF, 32'd1, 32'd0);
      run_rotor(175);

      // ---- the other way round ----
      req_idle_pct  = 81;
      rsp_stall_pct = 33;
      // bottom of the period, speed and offset ranges, longest timeout, reversed direction, never stops
      configure(32'd1, 32'd65535, 32'd0, 32'd0, 32'd1, 32'd1);
      run_rotor(175);

      // ---- neither side idles ----
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      configure($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(30, 0),
                $urandom_range(32'h1000_0000, 0), $urandom, $urandom_range(1), 32'd1);
      run_rotor(175);

      // all words in; let any stray result show up
      drain();
      repeat (80) @(posedge clock);
      if (rotor.mismatches == 0 && rotor.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

endmodule
